// File: rtl/rtpm_pkg.sv
// rtpm_pkg: shared types and constants of the routing table block
// command and config codes, route entry record, controller/datapath structs
// no dependencies
package rtpm_pkg;

  localparam int ADDR_W   = 32;
  localparam int METRIC_W = 8;
  localparam int CMD_W    = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [METRIC_W-1:0] METRIC_START = 8'd255;

  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_ADDRESS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_MASK       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_CONFIGURED = 2'd2;

  typedef struct packed {
    logic [ADDR_W-1:0]   network;
    logic [ADDR_W-1:0]   mask;
    logic [ADDR_W-1:0]   gateway;
    logic [METRIC_W-1:0] metric;
  } entry_t;

  typedef struct packed {
    logic load;
    logic issue;
    logic commit;
  } ctl_cmd_t;

  typedef struct packed {
    logic last_issue;
  } dp_status_t;

endpackage

// File: rtl/rtpm_ctrl.sv
// rtpm_ctrl: sequencer of the routing table block
// steps load, table scan, drain and commit; owns the result valid flag
// depends on rtpm_pkg
module rtpm_ctrl
  import rtpm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t dp_status,
  output ctl_cmd_t   ctl_cmd
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_DRAIN  = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt      = state_r;
    ctl_cmd.load   = 1'b0;
    ctl_cmd.issue  = 1'b0;
    ctl_cmd.commit = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl_cmd.load = 1'b1;
          state_nxt    = S_SCAN;
        end
      end
      S_SCAN: begin
        ctl_cmd.issue = 1'b1;
        if (dp_status.last_issue) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          ctl_cmd.commit = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl_cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: rtl/rtpm_datapath.sv
// rtpm_datapath: route memory, valid bits, config registers and scan evaluation
// one entry read per cycle, registered read data evaluated in the following cycle
// depends on rtpm_pkg
module rtpm_datapath
  import rtpm_pkg::*;
#(
  parameter int ROUTE_ENTRIES = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ctl_cmd_t             ctl_cmd,
  output dp_status_t           dp_status,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_wdata,
  input  logic [CMD_W-1:0]     in_cmd,
  input  logic [ADDR_W-1:0]    in_route_network,
  input  logic [ADDR_W-1:0]    in_route_mask,
  input  logic [ADDR_W-1:0]    in_route_gateway,
  input  logic [METRIC_W-1:0]  in_route_metric,
  input  logic [ADDR_W-1:0]    in_dest_address,
  output logic                 out_status,
  output logic [ADDR_W-1:0]    out_next_hop
);

  localparam int IW = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;

  entry_t mem [ROUTE_ENTRIES];

  logic [ROUTE_ENTRIES-1:0] valid_r, valid_nxt;

  logic [ADDR_W-1:0]   local_addr_r;
  logic [ADDR_W-1:0]   local_mask_r;
  logic                local_cfg_r;

  logic [CMD_W-1:0]    cmd_r;
  logic [ADDR_W-1:0]   dst_r;
  entry_t              ent_new_r;

  logic [IW-1:0]       idx_r;
  logic                rd_vld_r;
  logic [IW-1:0]       rd_idx_r;
  entry_t              rd_ent_r;

  logic [ADDR_W-1:0]   best_mask_r;
  logic [METRIC_W-1:0] best_metric_r;
  logic [ADDR_W-1:0]   best_gw_r;
  logic                found_r;
  logic [IW-1:0]       hit_idx_r;

  logic                out_status_r;
  logic [ADDR_W-1:0]   out_next_hop_r;

  logic ent_ok;
  logic same_route;
  logic dst_match;
  logic better;
  logic first_hit;
  logic lk_hit;
  logic local_hit;
  logic mem_we;

  assign dp_status.last_issue = (idx_r == IW'(ROUTE_ENTRIES - 1));

  // scan evaluation on the registered entry
  assign ent_ok     = valid_r[rd_idx_r];
  assign same_route = (rd_ent_r.network == ent_new_r.network) &&
                      (rd_ent_r.mask == ent_new_r.mask);
  assign dst_match  = ((dst_r & rd_ent_r.mask) == rd_ent_r.network);
  assign better     = (rd_ent_r.mask > best_mask_r) ||
                      ((rd_ent_r.mask == best_mask_r) && (rd_ent_r.metric < best_metric_r));
  assign first_hit  = rd_vld_r && !found_r &&
                      (((cmd_r == CMD_ADD) && !ent_ok) ||
                       ((cmd_r == CMD_REMOVE) && ent_ok && same_route));
  assign lk_hit     = rd_vld_r && (cmd_r == CMD_LOOKUP) && ent_ok && dst_match && better;
  assign local_hit  = local_cfg_r && (((local_addr_r ^ dst_r) & local_mask_r) == '0);
  assign mem_we     = ctl_cmd.commit && found_r && (cmd_r == CMD_ADD);

  assign out_status   = out_status_r;
  assign out_next_hop = out_next_hop_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_addr_r <= '0;
      local_mask_r <= '0;
      local_cfg_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LOCAL_ADDRESS:    local_addr_r <= cfg_wdata;
        CFG_LOCAL_MASK:       local_mask_r <= cfg_wdata;
        CFG_LOCAL_CONFIGURED: local_cfg_r  <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // route memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[hit_idx_r] <= ent_new_r;
    end
    if (ctl_cmd.issue) begin
      rd_ent_r <= mem[idx_r];
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (ctl_cmd.commit && found_r) begin
      case (cmd_r)
        CMD_ADD:    valid_nxt[hit_idx_r] = 1'b1;
        CMD_REMOVE: valid_nxt[hit_idx_r] = 1'b0;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      valid_r  <= valid_nxt;
      rd_vld_r <= ctl_cmd.issue;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_cmd.load) begin
      cmd_r             <= in_cmd;
      dst_r             <= in_dest_address;
      ent_new_r.network <= in_route_network;
      ent_new_r.mask    <= in_route_mask;
      ent_new_r.gateway <= in_route_gateway;
      ent_new_r.metric  <= in_route_metric;
      idx_r             <= '0;
      best_mask_r       <= '0;
      best_metric_r     <= METRIC_START;
      best_gw_r         <= '0;
      found_r           <= 1'b0;
      hit_idx_r         <= '0;
    end else begin
      if (ctl_cmd.issue) begin
        idx_r <= idx_r + IW'(1);
      end
      if (first_hit) begin
        found_r   <= 1'b1;
        hit_idx_r <= rd_idx_r;
      end
      if (lk_hit) begin
        best_mask_r   <= rd_ent_r.mask;
        best_metric_r <= rd_ent_r.metric;
        best_gw_r     <= rd_ent_r.gateway;
      end
    end
    if (ctl_cmd.issue) begin
      rd_idx_r <= idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_cmd.commit) begin
      case (cmd_r)
        CMD_ADD, CMD_REMOVE: begin
          out_status_r   <= !found_r;
          out_next_hop_r <= '0;
        end
        CMD_LOOKUP: begin
          out_status_r   <= 1'b0;
          out_next_hop_r <= local_hit ? '0 : best_gw_r;
        end
        default: begin
          out_status_r   <= 1'b0;
          out_next_hop_r <= '0;
        end
      endcase
    end
  end

endmodule

// File: rtl/route_table_prefix_match.sv
// route_table_prefix_match: top level of the routing table block
// joins the sequencer and the datapath
// depends on rtpm_pkg, rtpm_ctrl, rtpm_datapath
//
// Routing table of ROUTE_ENTRIES routes with add, remove and longest-prefix
// lookup; each item gives one result. Every command walks the whole table
// through the single read port of the route memory, one entry per cycle;
// the table scan is followed by the evaluation of the last read entry and
// then by the commit. One item is in work at a time; the next item can be
// accepted in the cycle after the previous one is committed to the output
// register, even if that result has not yet been taken. A result still
// waiting in the output register holds the commit of the next one. Config
// writes are applied at once and must only be made while no item is in
// flight.
module route_table_prefix_match
  import rtpm_pkg::*;
#(
  parameter int ROUTE_ENTRIES = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [CMD_W-1:0]     in_cmd,
  input  logic [ADDR_W-1:0]    in_route_network,
  input  logic [ADDR_W-1:0]    in_route_mask,
  input  logic [ADDR_W-1:0]    in_route_gateway,
  input  logic [METRIC_W-1:0]  in_route_metric,
  input  logic [ADDR_W-1:0]    in_dest_address,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_status,
  output logic [ADDR_W-1:0]    out_next_hop
);

  ctl_cmd_t   ctl_cmd;
  dp_status_t dp_status;

  rtpm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dp_status (dp_status),
    .ctl_cmd   (ctl_cmd)
  );

  rtpm_datapath #(
    .ROUTE_ENTRIES (ROUTE_ENTRIES)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctl_cmd          (ctl_cmd),
    .dp_status        (dp_status),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_cmd           (in_cmd),
    .in_route_network (in_route_network),
    .in_route_mask    (in_route_mask),
    .in_route_gateway (in_route_gateway),
    .in_route_metric  (in_route_metric),
    .in_dest_address  (in_dest_address),
    .out_status       (out_status),
    .out_next_hop     (out_next_hop)
  );

endmodule

// File: rtl/rtpm_checker.sv
// rtpm_checker: port-level assertions of the routing table block
// bound to route_table_prefix_match
// depends on rtpm_pkg
module rtpm_checker
  import rtpm_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_status,
  input logic [ADDR_W-1:0] out_next_hop
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_next_hop))
    else $error("result changed while stalled");

  // one item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after accepting an item");

  // error status only on add or remove, which carry no next hop
  a_status_hop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_next_hop == '0)
    else $error("error status with nonzero next hop");

  // no result straight out of reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind route_table_prefix_match rtpm_checker u_rtpm_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_status   (out_status),
  .out_next_hop (out_next_hop)
);

// File: bench/route_table_prefix_match_checker.sv
// route_table_prefix_match_checker: watches the item and result channels of the routing table,
// keeps its own copy of the routes and local subnet, and compares every result in order
// depends on rtpm_pkg
`timescale 1ns / 1ps

module route_table_prefix_match_checker
  import rtpm_pkg::*;
#(
  parameter int ROUTE_ENTRIES = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_wdata,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [CMD_W-1:0]     in_cmd,
  input  logic [ADDR_W-1:0]    in_route_network,
  input  logic [ADDR_W-1:0]    in_route_mask,
  input  logic [ADDR_W-1:0]    in_route_gateway,
  input  logic [METRIC_W-1:0]  in_route_metric,
  input  logic [ADDR_W-1:0]    in_dest_address,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic                 out_status,
  input  logic [ADDR_W-1:0]    out_next_hop,
  output int                   fail_count,
  output int                   pending
);

  typedef struct packed {
    logic              status;
    logic [ADDR_W-1:0] next_hop;
  } route_answer_t;

  logic [ADDR_W-1:0] local_addr;
  logic [ADDR_W-1:0] local_mask;
  logic              local_on;
  logic              route_used [ROUTE_ENTRIES];
  entry_t            route_tab  [ROUTE_ENTRIES];
  route_answer_t     expected_answers [$];
  int                mismatches = 0;

  assign fail_count = mismatches;

  task automatic report_mismatch(input string what, input logic [ADDR_W-1:0] want,
                                 input logic [ADDR_W-1:0] got);
    $display("%0t: %s: expected %h, got %h", $time, what, want, got);
    mismatches++;
  endtask

  function automatic route_answer_t predict_route_cmd(
    input logic [CMD_W-1:0]    cmd,
    input logic [ADDR_W-1:0]   net,
    input logic [ADDR_W-1:0]   msk,
    input logic [ADDR_W-1:0]   gw,
    input logic [METRIC_W-1:0] met,
    input logic [ADDR_W-1:0]   dst
  );
    route_answer_t       ans;
    logic [ADDR_W-1:0]   best_mask;
    logic [METRIC_W-1:0] best_metric;
    logic                done;
    ans = '0;
    done = 1'b0;
    case (cmd)
      CMD_ADD: begin
        ans.status = 1'b1;
        for (int k = 0; k < ROUTE_ENTRIES; k++) begin
          if (!done && !route_used[k]) begin
            route_tab[k] = '{network: net, mask: msk, gateway: gw, metric: met};
            route_used[k] = 1'b1;
            ans.status = 1'b0;
            done = 1'b1;
          end
        end
      end
      CMD_REMOVE: begin
        ans.status = 1'b1;
        for (int k = 0; k < ROUTE_ENTRIES; k++) begin
          if (!done && route_used[k] && route_tab[k].network == net &&
              route_tab[k].mask == msk) begin
            route_used[k] = 1'b0;
            ans.status = 1'b0;
            done = 1'b1;
          end
        end
      end
      CMD_LOOKUP: begin
        // local subnet answers direct without a scan
        if (!(local_on && ((local_addr ^ dst) & local_mask) == '0)) begin
          best_mask = '0;
          best_metric = METRIC_START;
          for (int k = 0; k < ROUTE_ENTRIES; k++) begin
            if (route_used[k] && (dst & route_tab[k].mask) == route_tab[k].network &&
                (route_tab[k].mask > best_mask ||
                 (route_tab[k].mask == best_mask && route_tab[k].metric < best_metric))) begin
              ans.next_hop = route_tab[k].gateway;
              best_mask = route_tab[k].mask;
              best_metric = route_tab[k].metric;
            end
          end
        end
      end
      default: ;
    endcase
    return ans;
  endfunction

  always @(posedge clk) begin
    route_answer_t want;
    if (!rst_n) begin
      local_addr = '0;
      local_mask = '0;
      local_on = 1'b0;
      for (int k = 0; k < ROUTE_ENTRIES; k++) route_used[k] = 1'b0;
      expected_answers.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_LOCAL_ADDRESS:    local_addr = cfg_wdata;
          CFG_LOCAL_MASK:       local_mask = cfg_wdata;
          CFG_LOCAL_CONFIGURED: local_on = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        expected_answers.push_back(predict_route_cmd(in_cmd, in_route_network, in_route_mask,
                                                     in_route_gateway, in_route_metric,
                                                     in_dest_address));
      if (out_valid && out_ready) begin
        if (expected_answers.size() == 0) begin
          report_mismatch("result with nothing pending", '0, out_next_hop);
        end else begin
          want = expected_answers.pop_front();
          if (out_status !== want.status)
            report_mismatch("status", ADDR_W'(want.status), ADDR_W'(out_status));
          if (out_next_hop !== want.next_hop)
            report_mismatch("next_hop", want.next_hop, out_next_hop);
        end
      end
    end
    pending <= expected_answers.size();
  end

endmodule

// File: bench/route_table_prefix_match_tb.sv
// route_table_prefix_match_tb: clock, reset, local subnet setup and route commands
// for the routing table; the checker beside the block predicts and compares
// depends on rtpm_pkg, route_table_prefix_match, route_table_prefix_match_checker
`timescale 1ns / 1ps

module route_table_prefix_match_tb;
  import rtpm_pkg::*;

  localparam int ROUTE_ENTRIES = 16;
  localparam int HOLD_CYCLES = 300;
  localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [ADDR_W-1:0]    cfg_wdata;
  logic                 in_valid;
  logic                 in_ready;
  logic [CMD_W-1:0]     in_cmd;
  logic [ADDR_W-1:0]    in_route_network;
  logic [ADDR_W-1:0]    in_route_mask;
  logic [ADDR_W-1:0]    in_route_gateway;
  logic [METRIC_W-1:0]  in_route_metric;
  logic [ADDR_W-1:0]    in_dest_address;
  logic                 out_valid;
  logic                 out_ready;
  logic                 out_status;
  logic [ADDR_W-1:0]    out_next_hop;
  int                   fail_count;
  int                   pending;

  logic                 idle_on = 1'b1;
  logic                 stall_req = 1'b0;
  logic [ADDR_W-1:0]    route_pool [4];
  logic [2*ADDR_W-1:0]  known_routes [$];

  route_table_prefix_match #(.ROUTE_ENTRIES(ROUTE_ENTRIES)) i_dut (.*);

  route_table_prefix_match_checker #(.ROUTE_ENTRIES(ROUTE_ENTRIES)) i_checker (.*);

  always #2 clk = ~clk;

  function automatic logic [ADDR_W-1:0] prefix_mask(input int len);
    return (len == 0) ? '0 : (32'hFFFF_FFFF << (32 - len));
  endfunction

  function automatic logic [ADDR_W-1:0] pick_mask();
    int pick;
    pick = $urandom_range(9);
    if (pick < 7) return prefix_mask($urandom_range(32));
    if (pick == 7) return $urandom;
    if (pick == 8) return '0;
    return 32'hFFFF_FFFF;
  endfunction

  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] net,
                           input logic [ADDR_W-1:0] msk, input logic [ADDR_W-1:0] gw,
                           input logic [METRIC_W-1:0] met, input logic [ADDR_W-1:0] dst);
    if (idle_on) begin
      while ($urandom_range(99) < 13) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_route_network <= net;
    in_route_mask <= msk;
    in_route_gateway <= gw;
    in_route_metric <= met;
    in_dest_address <= dst;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic random_item(input int add_pct, input int rem_pct);
    logic [CMD_W-1:0]    cmd;
    logic [ADDR_W-1:0]   net, msk, gw, dst;
    logic [METRIC_W-1:0] met;
    int                  roll, k;
    cmd = CMD_LOOKUP;
    net = $urandom;
    msk = $urandom;
    gw = $urandom;
    met = METRIC_W'($urandom);
    dst = $urandom;
    roll = $urandom_range(99);
    if (roll < add_pct) begin
      cmd = CMD_ADD;
      msk = pick_mask();
      if ($urandom_range(9) != 0) net = route_pool[$urandom_range(3)] & msk;
      if ($urandom_range(9) == 0) gw = '0;
      // small metrics make ties on equal masks common
      if ($urandom_range(1) == 0) met = METRIC_W'($urandom_range(3));
      known_routes.push_back({net, msk});
      if (known_routes.size() > 48) void'(known_routes.pop_front());
    end else if (roll < add_pct + rem_pct) begin
      cmd = CMD_REMOVE;
      if (known_routes.size() > 0 && $urandom_range(4) != 0) begin
        k = $urandom_range(known_routes.size() - 1);
        {net, msk} = known_routes[k];
        known_routes.delete(k);
      end
    end else if (roll < 97) begin
      if ($urandom_range(3) != 0)
        dst = route_pool[$urandom_range(3)] ^ ($urandom & ~prefix_mask($urandom_range(32)));
    end else begin
      cmd = CMD_RESERVED;
    end
    send_item(cmd, net, msk, gw, met, dst);
  endtask

  task automatic configure_local(input logic [ADDR_W-1:0] addr, input logic [ADDR_W-1:0] mask,
                                 input logic on);
    cfg_we <= 1'b1;
    cfg_index <= CFG_LOCAL_ADDRESS;
    cfg_wdata <= addr;
    @(posedge clk);
    cfg_index <= CFG_LOCAL_MASK;
    cfg_wdata <= mask;
    @(posedge clk);
    cfg_index <= CFG_LOCAL_CONFIGURED;
    cfg_wdata <= ($urandom & 32'hFFFF_FFFE) | ADDR_W'(on);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // receiver: random stalls while idle_on, plus a long hold-off whenever stall_req rises
  initial begin
    int   hold_left;
    logic stall_prev;
    hold_left = 0;
    stall_prev = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_req && !stall_prev) hold_left = HOLD_CYCLES;
      stall_prev = stall_req;
      if (!rst_n) begin
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (idle_on) begin
        out_ready <= ($urandom_range(99) >= 13);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("route_table_prefix_match_tb failed");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_cmd = '0;
    in_route_network = '0;
    in_route_mask = '0;
    in_route_gateway = '0;
    in_route_metric = '0;
    in_dest_address = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    configure_local('0, '0, 1'b0);

    // empty table, default routes, ties, odd masks, full table
    send_item(CMD_LOOKUP, '0, '0, '0, '0, 32'hFFFF_FFFF);
    send_item(CMD_REMOVE, 32'h0A00_0000, 32'hFF00_0000, '0, '0, '0);
    send_item(CMD_ADD, '0, '0, 32'h0101_0101, 8'd255, '0);
    send_item(CMD_LOOKUP, '0, '0, '0, '0, 32'h1234_5678);
    send_item(CMD_ADD, '0, '0, 32'h0202_0202, 8'd254, '0);
    send_item(CMD_ADD, 32'h0A00_0000, 32'hFF00_0000, 32'h0303_0303, 8'd10, '0);
    send_item(CMD_ADD, 32'h0A00_0000, 32'hFF00_0000, 32'h0404_0404, 8'd10, '0);
    send_item(CMD_ADD, 32'h0A00_0000, 32'hFF00_0000, 32'h0505_0505, 8'd5, '0);
    send_item(CMD_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd0, '0);
    send_item(CMD_ADD, 32'h0012_0034, 32'h00FF_00FF, 32'h0606_0606, 8'd0, '0);
    send_item(CMD_LOOKUP, '0, '0, '0, '0, 32'h0A12_0034);
    send_item(CMD_LOOKUP, '0, '0, '0, '0, 32'hFFFF_FFFF);
    send_item(CMD_LOOKUP, '0, '0, '0, '0, 32'h0012_0034);
    send_item(CMD_RESERVED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
    send_item(CMD_REMOVE, 32'h0A00_0000, 32'hFF00_0000, '0, '0, '0);
    send_item(CMD_LOOKUP, '0, '0, '0, '0, 32'h0A00_0001);
    for (int k = 0; k < 11; k++)
      send_item(CMD_ADD, 32'hC0A8_0000 + k, 32'hFFFF_FFFF, ADDR_W'(k), METRIC_W'(k), '0);
    wait_drained();

    configure_local(32'h0A00_0000, 32'hFFFF_0000, 1'b1);
    send_item(CMD_LOOKUP, '0, '0, '0, '0, 32'h0A00_0005);
    send_item(CMD_LOOKUP, '0, '0, '0, '0, 32'h0A01_0005);
    wait_drained();

    for (int p = 0; p < 8; p++) begin
      for (int k = 0; k < 4; k++) route_pool[k] = $urandom;
      case (p)
        0: configure_local(route_pool[0], prefix_mask(24), 1'b1);
        1: configure_local($urandom, $urandom, 1'b1);
        2: configure_local(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        3: configure_local(route_pool[1], '0, 1'b1);
        4: configure_local(route_pool[2], prefix_mask(16), 1'b0);
        5: configure_local('0, 32'hFFFF_FFFF, 1'b1);
        6: configure_local(route_pool[3], prefix_mask($urandom_range(32)), 1'b1);
        default: configure_local($urandom, $urandom, 1'b0);
      endcase
      idle_on <= (p != 4);
      for (int n = 0; n < 190; n++) begin
        if (p == 2 && n == 60) begin
          stall_req <= 1'b1;
          for (int j = 0; j < 24; j++) random_item(45, 20);
          stall_req <= 1'b0;
        end
        if (p == 5 && n == 95) wait_drained();
        if (p % 2 == 0) random_item(45, 20);
        else random_item(25, 35);
      end
      wait_drained();
    end

    repeat (ROUTE_ENTRIES + 8) @(posedge clk);
    if (fail_count == 0) begin
      $display("route_table_prefix_match_tb passed");
    end else begin
      $display("route_table_prefix_match_tb failed");
    end
    $finish;
  end

endmodule
